// ===== rtl/ddph_pkg.sv =====
// ----------------------------------------------------------------------------
// ddph_pkg: shared constants for the drive distance heading hold controller
// Widths of the digit serial multiplier and PID sums, the output limit,
// register indexes, action and product codes and configuration reset values.
// ----------------------------------------------------------------------------
package ddph_pkg;

  // Digit serial multiplier: signed multiplicand times unsigned multiplier,
  // one 4-bit digit of the multiplier per cycle, most significant first.
  localparam int DIG_W     = 4;
  localparam int MCAND_W   = 34;
  localparam int MPLIER_W  = 16;
  localparam int PROD_W    = MCAND_W + MPLIER_W;
  localparam int PP_W      = MCAND_W + DIG_W;
  localparam int NUM_DIG   = MPLIER_W / DIG_W;
  localparam int DIG_CNT_W = $clog2(NUM_DIG);

  // PID sum and heading product widths
  localparam int SP_W  = 46;
  localparam int ASP_W = 35;
  localparam int LR_W  = 36;
  localparam int MV_W  = LR_W + 7;

  // PID output limit: 100 percent in Q16
  localparam logic signed [SP_W-1:0] SPEED_LIM = SP_W'(100 * 65536);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KI     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DPR    = 3'd6;

  // Configuration reset values
  localparam logic [11:0] KI_RST     = 12'd0;
  localparam logic [11:0] KD_RST     = 12'd678;
  localparam logic [11:0] KH_RST     = 12'd640;
  localparam logic [15:0] SETTLE_RST = 16'd256;
  localparam logic [15:0] INTEG_RST  = 16'd256;
  localparam logic [5:0]  SLIMIT_RST = 6'd20;
  localparam logic [15:0] DPR_RST    = 16'd1960;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Products run on the shared multiplier, in this order
  typedef logic [2:0] op_t;
  localparam op_t OP_TRAVEL = 3'd0;
  localparam op_t OP_KP     = 3'd1;
  localparam op_t OP_KI     = 3'd2;
  localparam op_t OP_KD     = 3'd3;
  localparam op_t OP_HEAD   = 3'd4;

  localparam logic [5:0] SETTLE_MAX = 6'd63;

endpackage

// ===== rtl/drive_distance_pid_heading_hold.sv =====
// ----------------------------------------------------------------------------
// drive_distance_pid_heading_hold: distance PID with heading hold and settle
// Drive controller for a two sided base: distance PID with gated integral,
// delayed derivative, heading correction and settle / timeout detection.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_ready) takes one word per start or control
//   tick; output channel (out_valid / out_ready) returns exactly one word
//   per input word, in order. The config channel (cfg_valid / cfg_ready)
//   is always ready. The user must see that it is written only while the
//   block is idle; the block itself does not enforce this.
//   A start, an idle tick or a timeout tick goes straight to the output
//   stage; a normal tick runs all five products, a settling tick only the
//   travel product. One word is in work at a time; the next one is taken
//   the cycle after its result moves into the output register. Most of a
//   tick is spent on the one shared 34x4 bit digit multiplier, which runs
//   five 16-bit-multiplier products at one digit per cycle.
//   A multiply by the constant 120 mV per percent is done with shifts.
//   Reset (rst, synchronous) clears the move state and loads the default
//   gains and bands. While the receiver stalls the result holds in the
//   output register; one more input word is accepted and worked on, then
//   waits until the output register frees.
// ----------------------------------------------------------------------------
module drive_distance_pid_heading_hold (
  input  logic                                 clk,
  input  logic                                 rst,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  input  logic signed [17:0]                   target_distance,
  input  logic [9:0]                           timeout_ticks,
  input  logic [11:0]                          kp_gain,
  input  logic signed [21:0]                   heading,
  input  logic signed [31:0]                   left_rev,
  input  logic signed [31:0]                   right_rev,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   left_drive_mv,
  output logic signed [15:0]                   right_drive_mv,
  output logic signed [23:0]                   error_now,
  output logic                                 busy_res,
  output logic                                 settled,
  output logic                                 timed_out,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ddph_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                          cfg_data
);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_EVAL  = 4'd4;
  localparam logic [3:0] ST_CLAMP = 4'd5;
  localparam logic [3:0] ST_SIDES = 4'd6;
  localparam logic [3:0] ST_SCALE = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0] state;

  // configuration registers
  logic [11:0] integral_gain, derivative_gain, heading_gain;
  logic [15:0] settle_band, integrate_band, distance_per_rev;
  logic [5:0]  settle_limit;

  // move state
  logic               active;
  logic [5:0]         settle_count;
  logic signed [31:0] error_sum;
  logic signed [23:0] last_error, error_change;
  logic signed [21:0] heading_reference;
  logic signed [17:0] goal_distance;
  logic [11:0]        move_gain;
  logic [9:0]         elapsed_ticks, tick_budget;
  logic signed [31:0] left_origin, right_origin;

  // captured tick inputs
  logic signed [21:0] hd_q;
  logic signed [31:0] lr_q, rr_q;

  // work registers
  logic signed [22:0]                    aerr;
  logic signed [ddph_pkg::MCAND_W-1:0]   mcand;
  logic [ddph_pkg::MPLIER_W-1:0]         mplier;
  logic [ddph_pkg::DIG_CNT_W-1:0]        dig_cnt;
  logic signed [ddph_pkg::PROD_W-1:0]    acc;
  ddph_pkg::op_t                         op;
  logic signed [23:0]                    err_q;
  logic signed [ddph_pkg::SP_W-1:0]      sp;
  logic signed [ddph_pkg::ASP_W-1:0]     asp;
  logic signed [ddph_pkg::LR_W-1:0]      l_sum, r_sum;

  // staged result word
  logic signed [15:0] res_l, res_r;
  logic signed [23:0] res_err;
  logic               res_busy, res_st, res_to;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  logic in_acc, out_load;
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_gain    <= ddph_pkg::KI_RST;
      derivative_gain  <= ddph_pkg::KD_RST;
      heading_gain     <= ddph_pkg::KH_RST;
      settle_band      <= ddph_pkg::SETTLE_RST;
      integrate_band   <= ddph_pkg::INTEG_RST;
      settle_limit     <= ddph_pkg::SLIMIT_RST;
      distance_per_rev <= ddph_pkg::DPR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ddph_pkg::CFG_KI:     integral_gain    <= cfg_data[11:0];
        ddph_pkg::CFG_KD:     derivative_gain  <= cfg_data[11:0];
        ddph_pkg::CFG_KH:     heading_gain     <= cfg_data[11:0];
        ddph_pkg::CFG_SETTLE: settle_band      <= cfg_data;
        ddph_pkg::CFG_INTEG:  integrate_band   <= cfg_data;
        ddph_pkg::CFG_SLIMIT: settle_limit     <= cfg_data[5:0];
        ddph_pkg::CFG_DPR:    distance_per_rev <= cfg_data;
        default: ;
      endcase
    end
  end

  // encoder travel since start (sum of both sides) and heading error
  logic signed [ddph_pkg::MCAND_W-1:0] travel;
  logic signed [22:0]                  aerr_next;
  assign travel = ddph_pkg::MCAND_W'(lr_q) - ddph_pkg::MCAND_W'(left_origin)
                + ddph_pkg::MCAND_W'(rr_q) - ddph_pkg::MCAND_W'(right_origin);
  assign aerr_next = 23'(heading_reference) - 23'(hd_q);

  // operand select for the next product on the multiplier
  ddph_pkg::op_t                       launch_op;
  logic signed [ddph_pkg::MCAND_W-1:0] mcand_sel;
  logic [ddph_pkg::MPLIER_W-1:0]       mplier_sel;
  always_comb begin
    if (state == ST_PREP) launch_op = ddph_pkg::OP_TRAVEL;
    else if (state == ST_EVAL) launch_op = ddph_pkg::OP_KP;
    else launch_op = 3'(op + 3'd1);
    unique case (launch_op)
      ddph_pkg::OP_TRAVEL: begin
        mcand_sel  = travel;
        mplier_sel = distance_per_rev;
      end
      ddph_pkg::OP_KP: begin
        mcand_sel  = ddph_pkg::MCAND_W'(err_q);
        mplier_sel = ddph_pkg::MPLIER_W'(move_gain);
      end
      ddph_pkg::OP_KI: begin
        mcand_sel  = ddph_pkg::MCAND_W'(error_sum);
        mplier_sel = ddph_pkg::MPLIER_W'(integral_gain);
      end
      ddph_pkg::OP_KD: begin
        mcand_sel  = ddph_pkg::MCAND_W'(error_change);
        mplier_sel = ddph_pkg::MPLIER_W'(derivative_gain);
      end
      ddph_pkg::OP_HEAD: begin
        mcand_sel  = ddph_pkg::MCAND_W'(aerr);
        mplier_sel = ddph_pkg::MPLIER_W'(heading_gain);
      end
      default: begin
        mcand_sel  = '0;
        mplier_sel = '0;
      end
    endcase
  end

  // one digit step: acc = acc * 16 + mcand * top digit
  logic [ddph_pkg::DIG_W-1:0]         digit;
  logic signed [ddph_pkg::PP_W-1:0]   pp;
  logic signed [ddph_pkg::PROD_W-1:0] acc_next;
  assign digit    = mplier[ddph_pkg::MPLIER_W-1 -: ddph_pkg::DIG_W];
  assign pp       = mcand * $signed({1'b0, digit});
  assign acc_next = (acc <<< ddph_pkg::DIG_W) + ddph_pkg::PROD_W'(pp);

  // distance error: goal minus floor(travel * dpr / 2^17), saturated
  logic signed [32:0] dist_x;
  logic signed [33:0] err_diff;
  logic signed [23:0] err_sat;
  assign dist_x   = acc[ddph_pkg::PROD_W-1:17];
  assign err_diff = 34'(goal_distance) - 34'(dist_x);
  assign err_sat  = (err_diff[33:23] == {11{err_diff[23]}}) ? err_diff[23:0] :
                    (err_diff[33] ? 24'sh800000 : 24'sh7fffff);

  // band checks and settle counter
  logic signed [24:0] err_ext;
  logic [24:0]        abs_err;
  logic               in_settle, in_integ;
  logic [5:0]         settle_count_next;
  logic               settle_done;
  assign err_ext   = 25'(err_q);
  assign abs_err   = err_q[23] ? 25'(-err_ext) : 25'(err_ext);
  assign in_settle = abs_err < 25'(settle_band);
  assign in_integ  = abs_err < 25'(integrate_band);
  assign settle_count_next = !in_settle ? 6'd0 :
                             (settle_count != ddph_pkg::SETTLE_MAX) ?
                             6'(settle_count + 6'd1) : settle_count;
  assign settle_done = settle_count_next > settle_limit;

  // saturated integral and error change
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic signed [24:0] chg_wide;
  logic signed [23:0] chg_sat;
  assign sum_wide = 33'(error_sum) + 33'(err_q);
  assign sum_sat  = (sum_wide[32] == sum_wide[31]) ? sum_wide[31:0] :
                    (sum_wide[32] ? 32'sh80000000 : 32'sh7fffffff);
  assign chg_wide = 25'(err_q) - 25'(last_error);
  assign chg_sat  = (chg_wide[24] == chg_wide[23]) ? chg_wide[23:0] :
                    (chg_wide[24] ? 24'sh800000 : 24'sh7fffff);

  // side scaling: 120 mV per percent is x*128 - x*8, then floor by 2^16
  logic signed [ddph_pkg::MV_W-1:0] l_mv_wide, r_mv_wide;
  logic signed [26:0]               l_mv_q, r_mv_q;
  logic signed [15:0]               l_mv, r_mv;
  assign l_mv_wide = (ddph_pkg::MV_W'(l_sum) <<< 7) - (ddph_pkg::MV_W'(l_sum) <<< 3);
  assign r_mv_wide = (ddph_pkg::MV_W'(r_sum) <<< 7) - (ddph_pkg::MV_W'(r_sum) <<< 3);
  assign l_mv_q = l_mv_wide[ddph_pkg::MV_W-1:16];
  assign r_mv_q = r_mv_wide[ddph_pkg::MV_W-1:16];
  assign l_mv = (l_mv_q[26:15] == {12{l_mv_q[15]}}) ? l_mv_q[15:0] :
                (l_mv_q[26] ? 16'sh8000 : 16'sh7fff);
  assign r_mv = (r_mv_q[26:15] == {12{r_mv_q[15]}}) ? r_mv_q[15:0] :
                (r_mv_q[26] ? 16'sh8000 : 16'sh7fff);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      active            <= 1'b0;
      settle_count      <= '0;
      error_sum         <= '0;
      last_error        <= '0;
      error_change      <= '0;
      heading_reference <= '0;
      goal_distance     <= '0;
      move_gain         <= '0;
      elapsed_ticks     <= '0;
      tick_budget       <= '0;
      left_origin       <= '0;
      right_origin      <= '0;
      op                <= ddph_pkg::OP_TRAVEL;
      dig_cnt           <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            hd_q     <= heading;
            lr_q     <= left_rev;
            rr_q     <= right_rev;
            res_l    <= '0;
            res_r    <= '0;
            res_st   <= 1'b0;
            res_to   <= 1'b0;
            res_busy <= 1'b0;
            res_err  <= last_error;
            priority if (action == ddph_pkg::ACT_START) begin
              goal_distance     <= target_distance;
              tick_budget       <= timeout_ticks;
              move_gain         <= kp_gain;
              heading_reference <= heading;
              left_origin       <= left_rev;
              right_origin      <= right_rev;
              active            <= 1'b1;
              settle_count      <= '0;
              error_sum         <= '0;
              last_error        <= 24'(target_distance);
              error_change      <= '0;
              elapsed_ticks     <= '0;
              res_err           <= 24'(target_distance);
              res_busy          <= 1'b1;
              state             <= ST_OUT;
            end else if (!active) begin
              state <= ST_OUT;
            end else if (elapsed_ticks >= tick_budget) begin
              active <= 1'b0;
              res_to <= 1'b1;
              state  <= ST_OUT;
            end else begin
              elapsed_ticks <= 10'(elapsed_ticks + 10'd1);
              state         <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          aerr    <= aerr_next;
          mcand   <= mcand_sel;
          mplier  <= mplier_sel;
          op      <= launch_op;
          acc     <= '0;
          dig_cnt <= '0;
          state   <= ST_MUL;
        end
        ST_MUL: begin
          acc     <= acc_next;
          mplier  <= mplier << ddph_pkg::DIG_W;
          dig_cnt <= ddph_pkg::DIG_CNT_W'(dig_cnt + 1'b1);
          if (dig_cnt == ddph_pkg::DIG_CNT_W'(ddph_pkg::NUM_DIG - 1)) state <= ST_ACC;
        end
        ST_ACC: begin
          // consume the finished product; after KP, KI or KD start the next one
          unique case (op)
            ddph_pkg::OP_TRAVEL: begin
              err_q <= err_sat;
              state <= ST_EVAL;
            end
            ddph_pkg::OP_KP, ddph_pkg::OP_KI, ddph_pkg::OP_KD: begin
              sp      <= sp + ddph_pkg::SP_W'(acc);
              mcand   <= mcand_sel;
              mplier  <= mplier_sel;
              op      <= launch_op;
              acc     <= '0;
              dig_cnt <= '0;
              state   <= ST_MUL;
            end
            ddph_pkg::OP_HEAD: begin
              asp   <= acc[ddph_pkg::ASP_W-1:0];
              state <= ST_CLAMP;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_EVAL: begin
          settle_count <= settle_count_next;
          if (settle_done) begin
            active   <= 1'b0;
            res_l    <= '0;
            res_r    <= '0;
            res_err  <= err_q;
            res_busy <= 1'b0;
            res_st   <= 1'b1;
            res_to   <= 1'b0;
            state    <= ST_OUT;
          end else begin
            if (in_integ) error_sum <= sum_sat;
            sp      <= '0;
            mcand   <= mcand_sel;
            mplier  <= mplier_sel;
            op      <= launch_op;
            acc     <= '0;
            dig_cnt <= '0;
            state   <= ST_MUL;
          end
        end
        ST_CLAMP: begin
          if (sp > ddph_pkg::SPEED_LIM) sp <= ddph_pkg::SPEED_LIM;
          else if (sp < -ddph_pkg::SPEED_LIM) sp <= -ddph_pkg::SPEED_LIM;
          // derivative term takes effect on the next tick
          error_change <= chg_sat;
          last_error   <= err_q;
          state        <= ST_SIDES;
        end
        ST_SIDES: begin
          l_sum <= ddph_pkg::LR_W'(sp) + ddph_pkg::LR_W'(asp);
          r_sum <= ddph_pkg::LR_W'(sp) - ddph_pkg::LR_W'(asp);
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          res_l    <= l_mv;
          res_r    <= r_mv;
          res_err  <= err_q;
          res_busy <= 1'b1;
          res_st   <= 1'b0;
          res_to   <= 1'b0;
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_drive_mv  <= res_l;
      right_drive_mv <= res_r;
      error_now      <= res_err;
      busy_res       <= res_busy;
      settled        <= res_st;
      timed_out      <= res_to;
    end
  end

  // checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input taken while a word is in work");

  a_budget: assert property (@(posedge clk) disable iff (rst)
    elapsed_ticks <= tick_budget)
    else $error("elapsed ticks passed the tick budget");

  a_end_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(settled && timed_out) && !((settled || timed_out) && busy_res))
    else $error("end flags inconsistent with busy");

  a_mul_op: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (op <= ddph_pkg::OP_HEAD))
    else $error("multiplier running an unknown product");

  a_settle_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) && settle_done |=> !active && (state == ST_OUT))
    else $error("settle did not end the move");

endmodule
